### sv/dssr_pkg.sv
// ----------------------------------------------------------------------------
// dssr_pkg
// Shared types, register indexes and constants of the distance scaled speed
// regulator.
// ----------------------------------------------------------------------------
package dssr_pkg;

    localparam int unsigned DATA_W  = 16;
    localparam int unsigned RATIO_W = 17;
    localparam int unsigned INDEX_W = 3;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned PROD_W  = 2 * RATIO_W;

    // register indexes of the configuration port
    localparam logic [INDEX_W-1:0] REG_SET_SPEED   = 3'd0;
    localparam logic [INDEX_W-1:0] REG_SAFE_DIST   = 3'd1;
    localparam logic [INDEX_W-1:0] REG_BRAKE_DIST  = 3'd2;
    localparam logic [INDEX_W-1:0] REG_ACCEL_POWER = 3'd3;
    localparam logic [INDEX_W-1:0] REG_BRAKE_POWER = 3'd4;

    localparam logic [DATA_W-1:0] RST_SET_SPEED   = 16'd0;
    localparam logic [DATA_W-1:0] RST_SAFE_DIST   = 16'd3000;
    localparam logic [DATA_W-1:0] RST_BRAKE_DIST  = 16'd500;
    localparam logic [DATA_W-1:0] RST_ACCEL_POWER = 16'd0;
    localparam logic [DATA_W-1:0] RST_BRAKE_POWER = 16'd0;

    localparam logic [RATIO_W-1:0] RATIO_ONE = 17'd65536;

    // floor(x / 10) == (x * 52429) >> 19 for every 16-bit x
    localparam logic [RATIO_W-1:0] RECIP_TEN   = 17'd52429;
    localparam int unsigned        RECIP_SHIFT = 19;

    // index of the last quotient bit step of the ratio division
    localparam logic [CNT_W-1:0] DIV_LAST = 4'd15;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL_TGT,
        S_MUL_UP,
        S_MUL_DN,
        S_DIV10_UP,
        S_DIV10_DN,
        S_UPDATE
    } t_state;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_TGT,
        MUL_UP,
        MUL_DN,
        MUL_UP10,
        MUL_DN10
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     div_step;
        t_mul_sel mul_sel;
        logic     update;
    } t_dp_cmd;

    typedef struct packed {
        logic need_div;
        logic out_free;
    } t_dp_sts;

endpackage

### sv/dssr_ctrl.sv
// ----------------------------------------------------------------------------
// dssr_ctrl
// Sequencer: accepts an item, runs the ratio division when it is needed, the
// multiply steps and the speed update, then returns to idle.
// ----------------------------------------------------------------------------
module dssr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  dssr_pkg::t_dp_sts i_sts,
    output dssr_pkg::t_dp_cmd o_cmd
);

    dssr_pkg::t_state                r_state, n_state;
    logic [dssr_pkg::CNT_W-1:0]      r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dssr_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        o_in_ready    = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.div_step = 1'b0;
        o_cmd.mul_sel = dssr_pkg::MUL_NONE;
        o_cmd.update  = 1'b0;
        unique case (r_state)
            dssr_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                n_cnt      = '0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.need_div ? dssr_pkg::S_DIV : dssr_pkg::S_MUL_TGT;
                end
            end
            dssr_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == dssr_pkg::DIV_LAST) begin
                    n_state = dssr_pkg::S_MUL_TGT;
                end
            end
            dssr_pkg::S_MUL_TGT: begin
                o_cmd.mul_sel = dssr_pkg::MUL_TGT;
                n_state       = dssr_pkg::S_MUL_UP;
            end
            dssr_pkg::S_MUL_UP: begin
                o_cmd.mul_sel = dssr_pkg::MUL_UP;
                n_state       = dssr_pkg::S_MUL_DN;
            end
            dssr_pkg::S_MUL_DN: begin
                o_cmd.mul_sel = dssr_pkg::MUL_DN;
                n_state       = dssr_pkg::S_DIV10_UP;
            end
            dssr_pkg::S_DIV10_UP: begin
                o_cmd.mul_sel = dssr_pkg::MUL_UP10;
                n_state       = dssr_pkg::S_DIV10_DN;
            end
            dssr_pkg::S_DIV10_DN: begin
                o_cmd.mul_sel = dssr_pkg::MUL_DN10;
                n_state       = dssr_pkg::S_UPDATE;
            end
            dssr_pkg::S_UPDATE: begin
                // hold until the output register can take the result
                if (i_sts.out_free) begin
                    o_cmd.update = 1'b1;
                    n_state      = dssr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dssr_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### sv/dssr_dp.sv
// ----------------------------------------------------------------------------
// dssr_dp
// Datapath: configuration registers, radix-2 ratio divider, one shared
// multiplier, speed register and output register.
// ----------------------------------------------------------------------------
module dssr_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dssr_pkg::INDEX_W-1:0]  i_cfg_index,
    input  logic [dssr_pkg::DATA_W-1:0]   i_cfg_data,
    input  logic [dssr_pkg::DATA_W-1:0]   i_distance,
    input  dssr_pkg::t_dp_cmd             i_cmd,
    output dssr_pkg::t_dp_sts             o_sts,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [dssr_pkg::DATA_W-1:0]   o_speed,
    output logic [dssr_pkg::DATA_W-1:0]   o_target,
    output logic [dssr_pkg::RATIO_W-1:0]  o_ratio
);

    logic [dssr_pkg::DATA_W-1:0]  r_set_speed, r_safe_dist, r_brake_dist;
    logic [dssr_pkg::DATA_W-1:0]  r_accel_power, r_brake_power;
    logic [dssr_pkg::DATA_W-1:0]  r_cur_speed, n_cur_speed;
    logic [dssr_pkg::DATA_W-1:0]  r_rem, r_den;
    logic [dssr_pkg::RATIO_W-1:0] r_ratio;
    logic [dssr_pkg::DATA_W-1:0]  r_target, r_up, r_dn;
    logic                         r_out_valid;
    logic [dssr_pkg::DATA_W-1:0]  r_out_speed, r_out_target;
    logic [dssr_pkg::RATIO_W-1:0] r_out_ratio;

    logic                         w_above_brake, w_below_safe;
    logic [dssr_pkg::DATA_W:0]    w_rem2, w_rem_sub;
    logic                         w_ge;
    logic [dssr_pkg::RATIO_W-1:0] w_mul_a, w_mul_b;
    logic [dssr_pkg::PROD_W-1:0]  w_prod;
    logic [dssr_pkg::DATA_W:0]    w_sum;
    logic [dssr_pkg::DATA_W-1:0]  w_diff;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_speed   <= dssr_pkg::RST_SET_SPEED;
            r_safe_dist   <= dssr_pkg::RST_SAFE_DIST;
            r_brake_dist  <= dssr_pkg::RST_BRAKE_DIST;
            r_accel_power <= dssr_pkg::RST_ACCEL_POWER;
            r_brake_power <= dssr_pkg::RST_BRAKE_POWER;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dssr_pkg::REG_SET_SPEED:   r_set_speed   <= i_cfg_data;
                dssr_pkg::REG_SAFE_DIST:   r_safe_dist   <= i_cfg_data;
                dssr_pkg::REG_BRAKE_DIST:  r_brake_dist  <= i_cfg_data;
                dssr_pkg::REG_ACCEL_POWER: r_accel_power <= i_cfg_data;
                dssr_pkg::REG_BRAKE_POWER: r_brake_power <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_above_brake  = i_distance > r_brake_dist;
    assign w_below_safe   = i_distance < r_safe_dist;
    assign o_sts.need_div = w_above_brake && w_below_safe;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // remainder stays below the divisor, so only zeros are shifted in
    assign w_rem2    = {r_rem, 1'b0};
    assign w_ge      = w_rem2 >= {1'b0, r_den};
    assign w_rem_sub = w_rem2 - {1'b0, r_den};

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (i_cmd.mul_sel)
            dssr_pkg::MUL_TGT: begin
                w_mul_a = {1'b0, r_set_speed};
                w_mul_b = r_ratio;
            end
            dssr_pkg::MUL_UP: begin
                w_mul_a = {1'b0, r_accel_power};
                w_mul_b = r_ratio;
            end
            dssr_pkg::MUL_DN: begin
                w_mul_a = {1'b0, r_brake_power};
                w_mul_b = dssr_pkg::RATIO_ONE - r_ratio;
            end
            dssr_pkg::MUL_UP10: begin
                w_mul_a = {1'b0, r_up};
                w_mul_b = dssr_pkg::RECIP_TEN;
            end
            dssr_pkg::MUL_DN10: begin
                w_mul_a = {1'b0, r_dn};
                w_mul_b = dssr_pkg::RECIP_TEN;
            end
            default: begin
            end
        endcase
    end

    assign w_prod = {{(dssr_pkg::PROD_W-dssr_pkg::RATIO_W){1'b0}}, w_mul_a}
                  * {{(dssr_pkg::PROD_W-dssr_pkg::RATIO_W){1'b0}}, w_mul_b};

    // step toward the target and clamp at it
    assign w_sum  = {1'b0, r_cur_speed} + {1'b0, r_up};
    assign w_diff = r_cur_speed - r_target;

    always_comb begin
        n_cur_speed = r_cur_speed;
        if (r_cur_speed < r_target) begin
            n_cur_speed = (w_sum > {1'b0, r_target}) ? r_target : w_sum[dssr_pkg::DATA_W-1:0];
        end else if (r_cur_speed > r_target) begin
            n_cur_speed = (r_dn >= w_diff) ? r_target : r_cur_speed - r_dn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem   <= i_distance - r_brake_dist;
            r_den   <= r_safe_dist - r_brake_dist;
            r_ratio <= (w_above_brake && !w_below_safe) ? dssr_pkg::RATIO_ONE : '0;
        end else if (i_cmd.div_step) begin
            r_rem   <= w_ge ? w_rem_sub[dssr_pkg::DATA_W-1:0] : w_rem2[dssr_pkg::DATA_W-1:0];
            r_ratio <= {r_ratio[dssr_pkg::RATIO_W-2:0], w_ge};
        end
        case (i_cmd.mul_sel)
            dssr_pkg::MUL_TGT:  r_target <= w_prod[31:16];
            dssr_pkg::MUL_UP:   r_up     <= w_prod[31:16];
            dssr_pkg::MUL_DN:   r_dn     <= w_prod[31:16];
            dssr_pkg::MUL_UP10: r_up     <= {3'b000, w_prod[31:dssr_pkg::RECIP_SHIFT]};
            dssr_pkg::MUL_DN10: r_dn     <= {3'b000, w_prod[31:dssr_pkg::RECIP_SHIFT]};
            default: begin
            end
        endcase
        if (i_cmd.update) begin
            r_out_speed  <= n_cur_speed;
            r_out_target <= r_target;
            r_out_ratio  <= r_ratio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_speed <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.update) begin
                r_cur_speed <= n_cur_speed;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_speed     = r_out_speed;
    assign o_target    = r_out_target;
    assign o_ratio     = r_out_ratio;

endmodule

### sv/distance_scaled_speed_regulator.sv
// ----------------------------------------------------------------------------
// distance_scaled_speed_regulator
// Turns a distance sample into a ratio, a target speed and an updated speed.
// ----------------------------------------------------------------------------
// For a distance between brake and safe the accepted sample passes through
// 16 radix-2 divider steps, 5 passes of the single multiplier and 1 update;
// elsewhere the division is skipped. One sample at a time: a new sample is
// taken only after the last has reached the output register, and a stalled
// result holds the next one.
// Reset (synchronous, active low): defaults, zero speed, idle, output empty.
module distance_scaled_speed_regulator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dssr_pkg::INDEX_W-1:0]  i_cfg_index,
    input  logic [dssr_pkg::DATA_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [dssr_pkg::DATA_W-1:0]   i_distance,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [dssr_pkg::DATA_W-1:0]   o_speed,
    output logic [dssr_pkg::DATA_W-1:0]   o_target,
    output logic [dssr_pkg::RATIO_W-1:0]  o_ratio
);

    dssr_pkg::t_dp_cmd w_cmd;
    dssr_pkg::t_dp_sts w_sts;

    dssr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    dssr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_distance  (i_distance),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_speed     (o_speed),
        .o_target    (o_target),
        .o_ratio     (o_ratio)
    );

endmodule

### sv/dssr_checker.sv
// ----------------------------------------------------------------------------
// dssr_checker
// Port level checks of the speed regulator, bound to the top level.
// ----------------------------------------------------------------------------
module dssr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cfg_we,
    input logic [dssr_pkg::INDEX_W-1:0]  i_cfg_index,
    input logic [dssr_pkg::DATA_W-1:0]   i_cfg_data,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic [dssr_pkg::DATA_W-1:0]   i_distance,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [dssr_pkg::DATA_W-1:0]   o_speed,
    input logic [dssr_pkg::DATA_W-1:0]   o_target,
    input logic [dssr_pkg::RATIO_W-1:0]  o_ratio
);

    // ratio never exceeds one
    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_ratio <= dssr_pkg::RATIO_ONE))
        else $error("ratio above one");

    // zero ratio means zero target
    a_zero_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_ratio == '0)) |-> (o_target == '0))
        else $error("nonzero target at zero ratio");

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready right after accept");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_speed) && $stable(o_target) && $stable(o_ratio)))
        else $error("stalled result changed");

endmodule

bind distance_scaled_speed_regulator dssr_checker u_dssr_checker (.*);
